@@ hw/rtl/butterworth_lowpass_4th_order_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the fourth-order lowpass
// Shared forms for same-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef BUTTERWORTH_LOWPASS_4TH_ORDER_TOP_MACROS_SVH
`define BUTTERWORTH_LOWPASS_4TH_ORDER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BWLP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define BWLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bwlp_pkg.sv @@
// ----------------------------------------------------------------------------
// bwlp_pkg
// Types and fixed constants of the two-section biquad lowpass.
// ----------------------------------------------------------------------------
package bwlp_pkg;

  // fixed datapath widths
  localparam int COEF_W    = 32;
  localparam int HIST_W    = 32;
  localparam int PROD_W    = 64;
  localparam int ACC_W     = 64;
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;

  // coefficient register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_S1_GAIN = 3'd0,
    REG_S1_FB1  = 3'd1,
    REG_S1_FB2  = 3'd2,
    REG_S2_GAIN = 3'd3,
    REG_S2_FB1  = 3'd4,
    REG_S2_FB2  = 3'd5
  } reg_idx_t;

  localparam logic [COEF_W-1:0] COEF_RESET [NUM_REGS] = '{
    32'd138588000, 32'd229622000, 32'd56296000,
    32'd180327000, 32'd298777000, 32'd154098000
  };

  // tap steps of one section; two drain steps follow the last tap
  localparam int NUM_TAPS = 6;
  localparam logic [2:0] STEP_X0   = 3'd0;
  localparam logic [2:0] STEP_X1A  = 3'd1;
  localparam logic [2:0] STEP_X1B  = 3'd2;
  localparam logic [2:0] STEP_X2   = 3'd3;
  localparam logic [2:0] STEP_Y1   = 3'd4;
  localparam logic [2:0] STEP_Y2   = 3'd5;
  localparam logic [2:0] STEP_LAST = 3'd7;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC1,
    ST_RND1,
    ST_SEC2,
    ST_RND2,
    ST_FIN
  } state_t;

  // control into the shared multiply-accumulate unit
  typedef struct packed {
    logic issue;
    logic clear;
    logic sub;
  } mac_ctl_t;

endpackage

@@ hw/rtl/bwlp_if.sv @@
// ----------------------------------------------------------------------------
// bwlp_in_if / bwlp_out_if
// Valid/ready channels for input samples and filtered results.
// ----------------------------------------------------------------------------
interface bwlp_in_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           restart;
  logic                           end_of_buffer;

  modport source (output valid, sample_in, restart, end_of_buffer, input ready);
  modport sink   (input valid, sample_in, restart, end_of_buffer, output ready);
endinterface

interface bwlp_out_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           clipped;
  logic                           end_of_buffer_out;

  modport source (output valid, sample_out, clipped, end_of_buffer_out, input ready);
  modport sink   (input valid, sample_out, clipped, end_of_buffer_out, output ready);
endinterface

@@ hw/rtl/bwlp_mac.sv @@
// ----------------------------------------------------------------------------
// bwlp_mac
// Shared 32x32 multiplier with a saturating 64-bit accumulator.
// Operand register, product register, then accumulate: three stages.
// ----------------------------------------------------------------------------
module bwlp_mac
  import bwlp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [HIST_W-1:0] data,
  output logic signed [ACC_W-1:0]  acc
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [COEF_W-1:0] op_coef;
  logic signed [HIST_W-1:0] op_data;
  logic signed [PROD_W-1:0] prod;
  logic                     op_vld;
  logic                     op_sub;
  logic                     prod_vld;
  logic                     prod_sub;
  logic        [ACC_W:0]    sum;

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      op_vld   <= 1'b0;
      op_sub   <= 1'b0;
      prod_vld <= 1'b0;
      prod_sub <= 1'b0;
    end else begin
      op_vld   <= ctl.issue;
      op_sub   <= ctl.sub;
      prod_vld <= op_vld;
      prod_sub <= op_sub;
    end
  end

  // operand and product registers
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      op_coef <= coef;
      op_data <= data;
    end
    prod <= op_coef * op_data;
  end

  // saturating add or subtract of the product
  always_comb begin
    if (prod_sub) begin
      sum = {acc[ACC_W-1], acc} - {prod[PROD_W-1], prod};
    end else begin
      sum = {acc[ACC_W-1], acc} + {prod[PROD_W-1], prod};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc <= sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
        acc <= sum[ACC_W-1:0];
      end
    end
  end

endmodule

@@ hw/rtl/butterworth_lowpass_4th_order_top.sv @@
// ----------------------------------------------------------------------------
// Each accepted item runs through both sections in turn: a section runs 6 taps
//   through the one shared 32x32 multiply-accumulate unit, 2 drain steps and a
//   rounding state; a final output rounding state waits while the result register
//   is full, then the block returns to idle, the only state that accepts an item.
// Reset: synchronous, clears history, restores coefficient defaults, empties
//   the result register; the input is not ready while reset is held.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// butterworth_lowpass_4th_order_top
// Two cascaded direct-form-I biquad lowpass sections in fixed point, Q4.28
// coefficients, Q24.8 history, rounded and saturated sample output.
// ----------------------------------------------------------------------------
module butterworth_lowpass_4th_order_top
  import bwlp_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 28,
  parameter int HIST_FRAC_BITS = 8,
  parameter int SAMPLE_WIDTH   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  bwlp_in_if.sink              sample_chan,
  bwlp_out_if.source           result_chan,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  // saturation limits of the history format
  localparam logic signed [ACC_W-1:0] HIST_MAX = (ACC_W'(1) <<< (HIST_W - 1)) - 1;
  localparam logic signed [ACC_W-1:0] HIST_MIN = -(ACC_W'(1) <<< (HIST_W - 1));
  // section rounding
  localparam logic signed [ACC_W:0] ACC_HALF = (ACC_W + 1)'(1) <<< (COEF_FRAC_BITS - 1);
  // output rounding and clamp
  localparam int                     OUT_HALF    = (HIST_FRAC_BITS > 0) ?
                                                   (1 << (HIST_FRAC_BITS - 1)) : 0;
  localparam bit                     OUT_NEG_ADJ = (HIST_FRAC_BITS > 0);
  localparam logic signed [HIST_W:0] OUT_MAX = (HIST_W + 1)'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [HIST_W:0] OUT_MIN = -OUT_MAX - 1;

  state_t state, state_next;
  logic [2:0] step;

  logic signed [COEF_W-1:0] coef [NUM_REGS];

  logic signed [SAMPLE_WIDTH-1:0] x_cur;
  logic                           eob_cur;
  logic signed [SAMPLE_WIDTH-1:0] s1_in_prev1, s1_in_prev2;
  logic signed [HIST_W-1:0]       s1_out_prev1, s1_out_prev2;
  logic signed [HIST_W-1:0]       s2_in_prev1, s2_in_prev2;
  logic signed [HIST_W-1:0]       s2_out_prev1, s2_out_prev2;
  logic signed [HIST_W-1:0]       y1, y2;

  logic                           out_vld;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;
  logic                           out_clip;
  logic                           out_eob;
  logic                           out_free;
  logic                           in_take;

  mac_ctl_t                 mac_ctl;
  reg_idx_t                 coef_idx;
  logic signed [HIST_W-1:0] mac_data;
  logic signed [ACC_W-1:0]  acc;

  logic signed [SAMPLE_WIDTH-1:0] raw_smp;
  logic signed [ACC_W-1:0]        raw_scaled;
  logic signed [HIST_W-1:0]       hist_smp;

  logic signed [ACC_W:0]    rnd_sum;
  logic signed [ACC_W:0]    rnd_q;
  logic signed [HIST_W-1:0] sec_y;

  logic signed [HIST_W:0]         fin_sum;
  logic signed [HIST_W:0]         fin_q;
  logic signed [SAMPLE_WIDTH-1:0] fin_sample;
  logic                           fin_clip;

  assign in_take           = sample_chan.valid && sample_chan.ready;
  assign out_free          = !out_vld || result_chan.ready;
  assign sample_chan.ready = (state == ST_IDLE) && !rst;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef[i] <= COEF_RESET[i];
      end
    end else if (cfg_write && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      coef[cfg_index] <= cfg_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (sample_chan.valid) state_next = ST_SEC1;
      ST_SEC1: if (step == STEP_LAST) state_next = ST_RND1;
      ST_RND1: state_next = ST_SEC2;
      ST_SEC2: if (step == STEP_LAST) state_next = ST_RND2;
      ST_RND2: state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= (state == ST_SEC1 || state == ST_SEC2) ? step + 3'd1 : '0;
    end
  end

  // tap issue control
  always_comb begin
    mac_ctl       = '0;
    mac_ctl.issue = (state == ST_SEC1 || state == ST_SEC2) && (step < 3'(NUM_TAPS));
    mac_ctl.clear = mac_ctl.issue && (step == STEP_X0);
    mac_ctl.sub   = (step == STEP_Y1) || (step == STEP_Y2);
  end

  // coefficient select
  always_comb begin
    unique case (step) inside
      STEP_Y1: coef_idx = (state == ST_SEC2) ? REG_S2_FB1 : REG_S1_FB1;
      STEP_Y2: coef_idx = (state == ST_SEC2) ? REG_S2_FB2 : REG_S1_FB2;
      default: coef_idx = (state == ST_SEC2) ? REG_S2_GAIN : REG_S1_GAIN;
    endcase
  end

  // first section input sample, scaled to history format with saturation
  always_comb begin
    case (step) inside
      STEP_X1A, STEP_X1B: raw_smp = s1_in_prev1;
      STEP_X2:            raw_smp = s1_in_prev2;
      default:            raw_smp = x_cur;
    endcase
    raw_scaled = ACC_W'(raw_smp) <<< HIST_FRAC_BITS;
    if (raw_scaled > HIST_MAX) begin
      hist_smp = HIST_MAX[HIST_W-1:0];
    end else if (raw_scaled < HIST_MIN) begin
      hist_smp = HIST_MIN[HIST_W-1:0];
    end else begin
      hist_smp = raw_scaled[HIST_W-1:0];
    end
  end

  // data operand select
  always_comb begin
    if (state == ST_SEC2) begin
      case (step) inside
        STEP_X1A, STEP_X1B: mac_data = s2_in_prev1;
        STEP_X2:            mac_data = s2_in_prev2;
        STEP_Y1:            mac_data = s2_out_prev1;
        STEP_Y2:            mac_data = s2_out_prev2;
        default:            mac_data = y1;
      endcase
    end else begin
      case (step) inside
        STEP_Y1: mac_data = s1_out_prev1;
        STEP_Y2: mac_data = s1_out_prev2;
        default: mac_data = hist_smp;
      endcase
    end
  end

  bwlp_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .coef (coef[coef_idx]),
    .data (mac_data),
    .acc  (acc)
  );

  // section output: round half away from zero, saturate to 32 bits
  always_comb begin
    rnd_sum = {acc[ACC_W-1], acc} + ACC_HALF - (ACC_W + 1)'(acc[ACC_W-1]);
    rnd_q   = rnd_sum >>> COEF_FRAC_BITS;
    if (rnd_q > HIST_MAX) begin
      sec_y = HIST_MAX[HIST_W-1:0];
    end else if (rnd_q < HIST_MIN) begin
      sec_y = HIST_MIN[HIST_W-1:0];
    end else begin
      sec_y = rnd_q[HIST_W-1:0];
    end
  end

  // final output: round to integer, clamp to sample range
  always_comb begin
    fin_sum = {y2[HIST_W-1], y2} + (HIST_W + 1)'(OUT_HALF)
            - (HIST_W + 1)'(OUT_NEG_ADJ && y2[HIST_W-1]);
    fin_q   = fin_sum >>> HIST_FRAC_BITS;
    if (fin_q > OUT_MAX) begin
      fin_sample = OUT_MAX[SAMPLE_WIDTH-1:0];
      fin_clip   = 1'b1;
    end else if (fin_q < OUT_MIN) begin
      fin_sample = OUT_MIN[SAMPLE_WIDTH-1:0];
      fin_clip   = 1'b1;
    end else begin
      fin_sample = fin_q[SAMPLE_WIDTH-1:0];
      fin_clip   = 1'b0;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      x_cur   <= sample_chan.sample_in;
      eob_cur <= sample_chan.end_of_buffer;
    end
  end

  // section results
  always_ff @(posedge clk) begin
    if (state == ST_RND1) y1 <= sec_y;
    if (state == ST_RND2) y2 <= sec_y;
  end

  // filter history: restart clears on accept, sections shift at rounding
  always_ff @(posedge clk) begin
    if (rst || (in_take && sample_chan.restart)) begin
      s1_in_prev1  <= '0;
      s1_in_prev2  <= '0;
      s1_out_prev1 <= '0;
      s1_out_prev2 <= '0;
      s2_in_prev1  <= '0;
      s2_in_prev2  <= '0;
      s2_out_prev1 <= '0;
      s2_out_prev2 <= '0;
    end else if (state == ST_RND1) begin
      s1_in_prev2  <= s1_in_prev1;
      s1_in_prev1  <= x_cur;
      s1_out_prev2 <= s1_out_prev1;
      s1_out_prev1 <= sec_y;
    end else if (state == ST_RND2) begin
      s2_in_prev2  <= s2_in_prev1;
      s2_in_prev1  <= y1;
      s2_out_prev2 <= s2_out_prev1;
      s2_out_prev1 <= sec_y;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_vld <= 1'b1;
    end else if (result_chan.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_sample <= fin_sample;
      out_clip   <= fin_clip;
      out_eob    <= eob_cur;
    end
  end

  assign result_chan.valid             = out_vld;
  assign result_chan.sample_out        = out_sample;
  assign result_chan.clipped           = out_clip;
  assign result_chan.end_of_buffer_out = out_eob;

endmodule

@@ hw/rtl/bwlp_checker.sv @@
// ----------------------------------------------------------------------------
// bwlp_checker
// Port-level checks of the lowpass top level, attached by bind.
// ----------------------------------------------------------------------------
`include "butterworth_lowpass_4th_order_top_macros.svh"

module bwlp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // one item at a time: input closes right after an accept
  `BWLP_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "input still ready after accept")

  // a new result appears only as the sequencer returns to idle
  `BWLP_ASSERT_IMPL(a_result_opens_input, clk, rst, $rose(out_valid), in_ready, "result valid without input ready")

  // no stale result after reset
  `BWLP_ASSERT_IMPL(a_reset_clears_result, clk, rst, $fell(rst), !out_valid, "result valid out of reset")

  // a stalled result stays offered
  `BWLP_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

bind butterworth_lowpass_4th_order_top bwlp_checker u_bwlp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample_chan.valid),
  .in_ready  (sample_chan.ready),
  .out_valid (result_chan.valid),
  .out_ready (result_chan.ready)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the fourth-order biquad lowpass
// Streams samples through the valid/ready channels under random bursts and
// receiver stalls, predicts every filtered sample in fixed point alongside
// the block, and compares each result item field by field. Coefficient sets
// are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import bwlp_pkg::*;

  localparam int COEF_FRAC     = 28;
  localparam int HIST_FRAC     = 8;
  localparam int SAMPLE_W      = 16;
  localparam longint SAMPLE_MAX = 32767;
  localparam longint SAMPLE_MIN = -32768;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 25;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int FINAL_WAIT    = 5000;
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_ITEMS   = 150;

  localparam logic signed [31:0] DEFAULT_COEF [NUM_REGS] = '{
    32'sd138588000, 32'sd229622000, 32'sd56296000,
    32'sd180327000, 32'sd298777000, 32'sd154098000
  };

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
    logic                       eob;
  } filt_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  bwlp_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) in_ch ();
  bwlp_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) out_ch ();

  butterworth_lowpass_4th_order_top #(
    .COEF_FRAC_BITS(COEF_FRAC),
    .HIST_FRAC_BITS(HIST_FRAC),
    .SAMPLE_WIDTH  (SAMPLE_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .sample_chan(in_ch),
    .result_chan(out_ch),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of coefficients and filter history
  logic signed [31:0] coef_reg [NUM_REGS];
  int s1_x1, s1_x2, s1_y1, s1_y2;
  int s2_x1, s2_x2, s2_y1, s2_y2;

  filt_result_t expected_q [$];
  int errors         = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int clipped_seen   = 0;
  int restarts_sent  = 0;
  int settings_used  = 0;
  int stall_requests = 0;
  int cycle_count    = 0;
  logic signed [SAMPLE_W-1:0] last_sample = '0;

  // ---------------- fixed-point helpers ----------------
  function automatic longint sat_add64(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

  function automatic longint round_half_away(input longint v, input int sh);
    longint unsigned mag, r;
    if (sh == 0) return v;
    mag = (v >= 0) ? longint'(v) : 64'd0 - longint'(v);
    r = (mag >> sh) + ((mag >> (sh - 1)) & 64'd1);
    return (v >= 0) ? longint'(r) : -longint'(r);
  endfunction

  function automatic int clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic int to_hist(input int s);
    return clamp32(longint'(s) * (longint'(1) << HIST_FRAC));
  endfunction

  function automatic int biquad_section(input int g, a1, a2, x0, x1, x2, y1, y2);
    longint acc, p1;
    acc = longint'(g) * longint'(x0);
    p1  = longint'(g) * longint'(x1);
    acc = sat_add64(acc, p1);
    acc = sat_add64(acc, p1);
    acc = sat_add64(acc, longint'(g) * longint'(x2));
    acc = sat_add64(acc, -(longint'(a1) * longint'(y1)));
    acc = sat_add64(acc, -(longint'(a2) * longint'(y2)));
    return clamp32(round_half_away(acc, COEF_FRAC));
  endfunction

  task automatic clear_history();
    s1_x1 = 0; s1_x2 = 0; s1_y1 = 0; s1_y2 = 0;
    s2_x1 = 0; s2_x2 = 0; s2_y1 = 0; s2_y2 = 0;
  endtask

  // run one accepted sample through both sections, queue the expected item
  task automatic predict_filtered(input logic signed [SAMPLE_W-1:0] s, input logic rs,
                                  input logic eob);
    int x, y1, y2;
    longint r;
    filt_result_t res;
    x = int'(s);
    if (rs) clear_history();
    y1 = biquad_section(coef_reg[REG_S1_GAIN], coef_reg[REG_S1_FB1], coef_reg[REG_S1_FB2],
                        to_hist(x), to_hist(s1_x1), to_hist(s1_x2), s1_y1, s1_y2);
    s1_x2 = s1_x1; s1_x1 = x;
    s1_y2 = s1_y1; s1_y1 = y1;
    y2 = biquad_section(coef_reg[REG_S2_GAIN], coef_reg[REG_S2_FB1], coef_reg[REG_S2_FB2],
                        y1, s2_x1, s2_x2, s2_y1, s2_y2);
    s2_x2 = s2_x1; s2_x1 = y1;
    s2_y2 = s2_y1; s2_y1 = y2;
    r = round_half_away(longint'(y2), HIST_FRAC);
    res.clipped = 1'b0;
    if (r > SAMPLE_MAX) begin
      r = SAMPLE_MAX;
      res.clipped = 1'b1;
    end
    if (r < SAMPLE_MIN) begin
      r = SAMPLE_MIN;
      res.clipped = 1'b1;
    end
    res.sample = r[SAMPLE_W-1:0];
    res.eob    = eob;
    expected_q.push_back(res);
  endtask

  // ---------------- stimulus primitives ----------------
  // offer one item; valid stays high afterwards until a pause lowers it
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic rs,
                             input logic eob);
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.sample_in     <= s;
    in_ch.restart       <= rs;
    in_ch.end_of_buffer <= eob;
    do @(posedge clk); while (!in_ch.ready);
    predict_filtered(s, rs, eob);
    items_sent++;
    if (rs) restarts_sent++;
  endtask

  task automatic pause_input(input int n);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_idle();
    pause_input(1);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_coef(input reg_idx_t idx, input logic signed [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    coef_reg[idx] = val;
  endtask

  task automatic write_all(input logic signed [31:0] g1, f11, f12, g2, f21, f22);
    write_coef(REG_S1_GAIN, g1);
    write_coef(REG_S1_FB1, f11);
    write_coef(REG_S1_FB2, f12);
    write_coef(REG_S2_GAIN, g2);
    write_coef(REG_S2_FB1, f21);
    write_coef(REG_S2_FB2, f22);
    settings_used++;
  endtask

  // coefficient sets for the random phases
  task automatic load_profile(input int kind);
    logic signed [31:0] v [NUM_REGS];
    for (int k = 0; k < NUM_REGS; k++) begin
      case (kind)
        0: v[k] = DEFAULT_COEF[k];
        1: v[k] = DEFAULT_COEF[k] + int'($urandom_range(0, 1 << 23)) - (1 << 22);
        2: v[k] = $urandom;
        3: v[k] = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        default: begin
          // loud: gains near unity, weak feedback, so clipping is common
          if (k == REG_S1_GAIN || k == REG_S2_GAIN)
            v[k] = int'($urandom_range(1 << 26, 1 << 29));
          else
            v[k] = int'($urandom_range(0, 1 << 27)) - (1 << 26);
        end
      endcase
    end
    write_all(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] next_sample();
    case ($urandom_range(0, 9))
      0:       last_sample = 16'sh7FFF;
      1:       last_sample = 16'sh8000;
      2, 3:    last_sample = 16'(int'($urandom_range(0, 1023)) - 512);
      4:       ; // step input: repeat the previous value
      default: last_sample = 16'($urandom);
    endcase
    return last_sample;
  endfunction

  // buffers starting with restart and ending with end_of_buffer, plus noise
  task automatic send_stream(input int count, input bit gapless);
    int burst, buf_left;
    logic rs, eob;
    burst = 0;
    buf_left = 0;
    for (int i = 0; i < count; i++) begin
      if (buf_left == 0) begin
        buf_left = $urandom_range(1, 60);
        rs = ($urandom_range(0, 3) != 0);
      end else begin
        rs = 1'b0;
      end
      buf_left--;
      eob = (buf_left == 0);
      if ($urandom_range(0, 19) == 0) rs = ~rs;
      if ($urandom_range(0, 19) == 0) eob = ~eob;
      send_sample(next_sample(), rs, eob);
      if (!gapless) begin
        if (burst == 0) begin
          pause_input($urandom_range(1, 15));
          burst = $urandom_range(1, 24);
        end else begin
          burst--;
        end
      end
    end
  endtask

  // ---------------- tests ----------------
  // impulse and extremes under reset coefficients
  task automatic test_impulse_defaults();
    send_sample(16'sh7FFF, 1'b1, 1'b0);
    send_sample(16'sh0000, 1'b0, 1'b0);
    send_sample(16'sh0000, 1'b0, 1'b0);
    send_sample(16'sh0000, 1'b0, 1'b0);
    send_sample(16'sh8000, 1'b0, 1'b1);
    send_sample(16'sh0000, 1'b0, 1'b0);
    send_sample(16'sh0001, 1'b1, 1'b0);
    wait_idle();
  endtask

  // exact halves at the section output and at the final rounding
  task automatic test_rounding();
    write_all(32'sh1000_0000, 32'sd0, 32'sd0, 32'sh0010_0000, 32'sd0, 32'sd0);
    send_sample(16'sd128, 1'b1, 1'b0);
    send_sample(-16'sd128, 1'b1, 1'b1);
    send_sample(16'sd1, 1'b1, 1'b0);
    send_sample(-16'sd129, 1'b1, 1'b0);
    wait_idle();
    write_coef(REG_S1_GAIN, 32'sh0008_0000);
    send_sample(16'sd1, 1'b1, 1'b1);
    send_sample(-16'sd1, 1'b1, 1'b0);
    wait_idle();
  endtask

  // accumulator saturation, section saturation and output clipping
  task automatic test_saturation();
    write_all(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_sample(16'sh8000, 1'b1, 1'b0);
    send_sample(16'sh8000, 1'b0, 1'b0);
    send_sample(16'sh8000, 1'b0, 1'b0);
    send_sample(16'sh7FFF, 1'b0, 1'b1);
    wait_idle();
    write_all(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_sample(16'sh7FFF, 1'b1, 1'b0);
    send_sample(16'sh7FFF, 1'b0, 1'b0);
    send_sample(16'sh8000, 1'b0, 1'b1);
    wait_idle();
    write_all(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
    send_sample(16'sh7FFF, 1'b1, 1'b0);
    send_sample(16'sh8000, 1'b0, 1'b0);
    send_sample(16'sh0000, 1'b1, 1'b1);
    wait_idle();
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    load_profile(0);
    stall_requests++;
    send_stream(40, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_streams();
    int kind;
    for (int p = 0; p < RAND_PHASES; p++) begin
      kind = (p == 0) ? 0 : (p == 1) ? 2 : (p == 2) ? 3 : $urandom_range(0, 4);
      load_profile(kind);
      send_stream(PHASE_ITEMS, (p % 4) == 3);
      wait_idle();
    end
  endtask

  // ---------------- receiver ----------------
  initial begin : result_sink
    logic [15:0] ready_pat;
    int pat_left, hold, served;
    out_ch.ready = 1'b0;
    ready_pat = '1;
    pat_left = 0;
    hold = 0;
    served = 0;
    forever begin
      @(negedge clk);
      if (served != stall_requests) begin
        served = stall_requests;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          case ($urandom_range(0, 3))
            0:       ready_pat = '1;
            1:       ready_pat = 16'($urandom);
            2:       ready_pat = 16'($urandom | $urandom);
            default: ready_pat = 16'($urandom & $urandom) | 16'h0001;
          endcase
          pat_left = $urandom_range(16, 128);
        end
        out_ch.ready <= ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[15:1]};
        pat_left--;
      end
    end
  end

  // ---------------- result check ----------------
  always @(posedge clk) begin : result_check
    filt_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.clipped) clipped_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item: sample_out %0d clipped %0b eob %0b",
                 $time, out_ch.sample_out, out_ch.clipped, out_ch.end_of_buffer_out);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.sample_out !== want.sample) begin
          errors++;
          $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                   $time, want.sample, out_ch.sample_out);
        end
        if (out_ch.clipped !== want.clipped) begin
          errors++;
          $display("%0t: clipped mismatch: expected %0b, actual %0b",
                   $time, want.clipped, out_ch.clipped);
        end
        if (out_ch.end_of_buffer_out !== want.eob) begin
          errors++;
          $display("%0t: end_of_buffer_out mismatch: expected %0b, actual %0b",
                   $time, want.eob, out_ch.end_of_buffer_out);
        end
      end
    end
  end

  // ---------------- run limit ----------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, expected_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin : main_seq
    int waited;
    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.sample_in     = '0;
    in_ch.restart       = 1'b0;
    in_ch.end_of_buffer = 1'b0;
    cfg_write           = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    for (int k = 0; k < NUM_REGS; k++) coef_reg[k] = DEFAULT_COEF[k];
    clear_history();
    settings_used = 1;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_impulse_defaults();
    test_rounding();
    test_saturation();
    test_backpressure();
    test_random_streams();

    // drain, then let the block settle
    pause_input(1);
    waited = 0;
    while (expected_q.size() != 0 && waited < FINAL_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      errors += expected_q.size();
      $display("%0t: %0d expected result items never arrived", $time, expected_q.size());
    end

    $display("Covered %0d samples (%0d with restart) over %0d coefficient sets.",
             items_sent, restarts_sent, settings_used);
    $display("Checked %0d result items, %0d of them clipped, %0d errors.",
             results_seen, clipped_seen, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
